/* hw/rtl/dacc_pkg.sv */
// shared types and constants for the decimal accumulator cpu
`default_nettype none
package dacc_pkg;

  localparam int WordW = 15;
  localparam int InW   = 18;

  localparam logic signed [WordW-1:0] WordMax   = 15'sd9999;
  localparam logic signed [WordW-1:0] WordMin   = -15'sd9999;
  localparam logic signed [WordW-1:0] WordReset = 15'sd7777;
  localparam logic signed [InW-1:0]   EndMark   = -18'sd99999;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_HALT     = 4'd1,
    ST_BADLOAD  = 4'd2,
    ST_TOOLARGE = 4'd3,
    ST_ILLIN    = 4'd4,
    ST_OVER     = 4'd5,
    ST_UNDER    = 4'd6,
    ST_DIVZ     = 4'd7,
    ST_BADOP    = 4'd8,
    ST_ADDR     = 4'd9,
    ST_STOPPED  = 4'd10
  } status_e;

  typedef enum logic [6:0] {
    OP_READ   = 7'd11,
    OP_WRITE  = 7'd12,
    OP_LOAD   = 7'd21,
    OP_STORE  = 7'd22,
    OP_ADD    = 7'd31,
    OP_SUB    = 7'd32,
    OP_MUL    = 7'd33,
    OP_DIV    = 7'd34,
    OP_BR     = 7'd41,
    OP_BRNEG  = 7'd42,
    OP_BRZERO = 7'd43,
    OP_HALT   = 7'd44
  } opcode_e;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;   // sweep the store after reset
    logic latch_in;     // capture the input word
    logic do_load;      // load-mode step
    logic fetch;        // read word at pc
    logic decode;       // split instruction, start operand read
    logic div_start;    // launch divider
    logic exec;         // commit the instruction
    logic emit;         // drive the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic mode;
    logic div_needed;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/decimal_accumulator_cpu.sv */
// Decimal accumulator cpu. After reset the block fills its word store with 7777 and
// holds busy high meanwhile. A word is taken when start is high and busy low. A load
// step runs dispatch and emit; an instruction runs dispatch, fetch, decode, operand,
// execute and emit, a divide waiting for the bit-serial divider before execute. The
// result shows on the ports with done_o high for exactly one cycle; it cannot stall.
`default_nettype none
module decimal_accumulator_cpu import dacc_pkg::*; #(
  parameter int MEM_WORDS = 100
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    mode_i,
  input  wire logic signed [InW-1:0]   word_in_i,
  output logic                         done_o,
  output logic [3:0]                   status_o,
  output logic                         write_valid_o,
  output logic signed [WordW-1:0]      write_word_o,
  output logic signed [WordW-1:0]      acc_value_o,
  output logic [6:0]                   pc_value_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  dacc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o
  );

  dacc_datapath #(.MemWords(MEM_WORDS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .mode_i,
    .word_in_i,
    .status_o,
    .write_valid_o,
    .write_word_o,
    .acc_value_o,
    .pc_value_o
  );
endmodule
`default_nettype wire

/* hw/rtl/dacc_div.sv */
// iterative signed divider, truncating toward zero, one quotient bit per cycle
`default_nettype none
module dacc_div import dacc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [WordW-1:0] dividend_i,
  input  wire logic signed [WordW-1:0] divisor_i,
  output logic                         done_o,
  output logic signed [WordW:0]        quot_o
);
  localparam int CntW = $clog2(WordW + 1);

  logic [WordW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic             neg_q, neg_d, run_q, run_d, done_d, done_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW:0]   trial;
  logic [WordW-1:0] shifted;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    shifted = {rem_q[WordW-2:0], quo_q[WordW-1]};
    trial   = {1'b0, shifted} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i[WordW-1] ? WordW'(-dividend_i) : dividend_i;
      dvs_d = divisor_i[WordW-1] ? WordW'(-divisor_i) : divisor_i;
      neg_d = dividend_i[WordW-1] ^ divisor_i[WordW-1];
      run_d = 1'b1;
      cnt_d = '0;
    end else if (run_q) begin
      if (!trial[WordW]) begin
        rem_d = trial[WordW-1:0];
      end else begin
        rem_d = shifted;
      end
      quo_d = {quo_q[WordW-2:0], ~trial[WordW]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WordW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule
`default_nettype wire

/* hw/rtl/dacc_datapath.sv */
// word store, accumulator, counters and instruction execution
`default_nettype none
module dacc_datapath import dacc_pkg::*; #(
  parameter int MemWords = 100
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_cmd_t                 cmd_i,
  output dp_stat_t                     stat_o,
  input  wire logic                    mode_i,
  input  wire logic signed [InW-1:0]   word_in_i,
  output logic [3:0]                   status_o,
  output logic                         write_valid_o,
  output logic signed [WordW-1:0]      write_word_o,
  output logic signed [WordW-1:0]      acc_value_o,
  output logic [6:0]                   pc_value_o
);
  localparam int AddrW = $clog2(MemWords);

  logic signed [WordW-1:0] mem_q [MemWords];
  logic signed [WordW-1:0] rd_q;
  logic [AddrW-1:0]        rd_addr;
  logic                    we;
  logic [AddrW-1:0]        wr_addr;
  logic signed [WordW-1:0] wr_data;

  logic signed [WordW-1:0] acc_q, instr_q, mul_q;
  logic [6:0]              pc_q, lptr_q, clr_q;
  logic                    stopped_q, mode_q, clear_done_q;
  logic signed [InW-1:0]   win_q;
  logic [6:0]              op_q, opd_q;
  logic [6:0]              op_d, opd_d;
  logic signed [WordW-1:0] instr_abs;
  logic [13:0]             abs_mul;
  logic [6:0]              quo_abs, rem_abs;

  logic                    div_done;
  logic signed [WordW:0]   div_q;

  logic [3:0]              st;
  logic                    wv;
  logic signed [WordW-1:0] ww;
  logic signed [WordW+1:0] sum;
  logic signed [31:0]      prod;
  logic                    win_ok;

  dacc_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (rd_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // fetch reads pc, decode reads operand
  always_comb begin
    if (cmd_i.fetch) begin
      rd_addr = pc_q[AddrW-1:0];
    end else begin
      rd_addr = opd_q[AddrW-1:0];
    end
  end

  // split word into opcode and operand by reciprocal multiply on magnitude
  always_comb begin
    instr_abs = instr_q[WordW-1] ? -instr_q : instr_q;
    abs_mul   = 14'(instr_abs);
    quo_abs   = 7'((32'(abs_mul) * 32'd5243) >> 19);
    rem_abs   = 7'(abs_mul - 14'(quo_abs) * 14'd100);
    op_d      = instr_q[WordW-1] ? 7'(-quo_abs) : quo_abs;
    opd_d     = instr_q[WordW-1] ? 7'(-rem_abs) : rem_abs;
  end

  assign win_ok = (win_q >= InW'(WordMin)) && (win_q <= InW'(WordMax));
  assign sum    = (op_q == OP_SUB) ? (WordW+2)'(acc_q) - (WordW+2)'(rd_q)
                                   : (WordW+2)'(acc_q) + (WordW+2)'(rd_q);
  assign prod   = 32'(acc_q) * 32'(rd_q);

  // execute: status, writes, next state
  always_comb begin
    logic signed [31:0] res;
    logic               jump, setacc, neg_op;
    logic [6:0]         pc_n;
    st     = ST_OK;
    wv     = 1'b0;
    ww     = '0;
    we     = 1'b0;
    wr_addr = lptr_q[AddrW-1:0];
    wr_data = WordW'(win_q);
    res    = '0;
    jump   = 1'b0;
    setacc = 1'b0;
    pc_n   = pc_q + 7'd1;
    neg_op = instr_q[WordW-1];
    if (cmd_i.clear_step) begin
      we      = 1'b1;
      wr_addr = clr_q[AddrW-1:0];
      wr_data = WordReset;
    end else if (stopped_q) begin
      st = ST_STOPPED;
    end else if (!mode_q) begin
      if (win_q == EndMark) begin
        st = ST_OK;
      end else if (!win_ok) begin
        st = ST_BADLOAD;
      end else if (lptr_q >= 7'(MemWords)) begin
        st = ST_TOOLARGE;
      end else begin
        we = cmd_i.do_load;
      end
    end else if (pc_q >= 7'(MemWords)) begin
      st = ST_ADDR;
    end else if (!neg_op && op_q == OP_HALT) begin
      st = ST_HALT;
    end else if (neg_op || !(op_q == OP_READ || op_q == OP_WRITE || op_q == OP_LOAD ||
                 op_q == OP_STORE || op_q == OP_ADD || op_q == OP_SUB ||
                 op_q == OP_MUL || op_q == OP_DIV || op_q == OP_BR ||
                 op_q == OP_BRNEG || op_q == OP_BRZERO)) begin
      st = ST_BADOP;
    end else if (opd_q >= 7'(MemWords)) begin
      st = ST_ADDR;
    end else begin
      unique case (op_q)
        OP_READ: begin
          if (!win_ok) begin
            st = ST_ILLIN;
          end else begin
            we      = cmd_i.exec;
            wr_addr = opd_q[AddrW-1:0];
          end
        end
        OP_WRITE: begin
          wv = 1'b1;
          ww = rd_q;
        end
        OP_LOAD: begin
          setacc = 1'b1;
          res    = 32'(rd_q);
        end
        OP_STORE: begin
          we      = cmd_i.exec;
          wr_addr = opd_q[AddrW-1:0];
          wr_data = acc_q;
        end
        OP_ADD, OP_SUB: begin
          setacc = 1'b1;
          res    = 32'(sum);
        end
        OP_MUL: begin
          setacc = 1'b1;
          res    = 32'(mul_q);
          if (prod > 32'sd9999) st = ST_OVER;
          else if (prod < -32'sd9999) st = ST_UNDER;
        end
        OP_DIV: begin
          if (rd_q == '0) begin
            st = ST_DIVZ;
          end else begin
            setacc = 1'b1;
            res    = 32'(div_q);
          end
        end
        OP_BR:    jump = 1'b1;
        OP_BRNEG: jump = acc_q[WordW-1];
        default:  jump = (acc_q == '0);
      endcase
      if (setacc && op_q != OP_MUL) begin
        if (res > 32'sd9999) st = ST_OVER;
        else if (res < -32'sd9999) st = ST_UNDER;
      end
      if (st == ST_OK) begin
        if (!jump && pc_n >= 7'(MemWords)) st = ST_ADDR;
      end
    end
    if (st != ST_OK) begin
      wv = 1'b0;
      ww = '0;
    end
  end

  // commit logic needs the same decisions; recompute the pieces it needs
  logic       exec_ok, exec_jump, exec_setacc, exec_pcadv;
  logic signed [WordW-1:0] exec_acc;
  always_comb begin
    exec_ok     = mode_q && !stopped_q && (st == ST_OK || st == ST_ADDR) &&
                  pc_q < 7'(MemWords) && !instr_q[WordW-1] && opd_q < 7'(MemWords);
    exec_jump   = (op_q == OP_BR) || (op_q == OP_BRNEG && acc_q[WordW-1]) ||
                  (op_q == OP_BRZERO && acc_q == '0);
    exec_setacc = (op_q == OP_LOAD) || (op_q == OP_ADD) || (op_q == OP_SUB) ||
                  (op_q == OP_MUL) || (op_q == OP_DIV);
    exec_pcadv  = exec_ok && (st == ST_OK || (st == ST_ADDR && !exec_jump));
    if (op_q == OP_LOAD) exec_acc = rd_q;
    else if (op_q == OP_MUL) exec_acc = mul_q;
    else if (op_q == OP_DIV) exec_acc = WordW'(div_q);
    else exec_acc = WordW'(sum);
  end

  always_ff @(posedge clk_i) begin
    if (we && (cmd_i.clear_step || cmd_i.do_load || cmd_i.exec)) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
    if (cmd_i.latch_in) begin
      win_q  <= word_in_i;
      mode_q <= mode_i;
    end
    if (cmd_i.fetch) instr_q <= mem_q[pc_q[AddrW-1:0]];
    if (cmd_i.decode) begin
      op_q  <= op_d;
      opd_q <= opd_d;
    end
    mul_q <= WordW'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      pc_q          <= '0;
      lptr_q        <= '0;
      clr_q         <= '0;
      clear_done_q  <= 1'b0;
      stopped_q     <= 1'b0;
      status_o      <= ST_OK;
      write_valid_o <= 1'b0;
      write_word_o  <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 7'd1;
        if (clr_q == 7'(MemWords - 1)) clear_done_q <= 1'b1;
      end
      if (cmd_i.do_load && we) lptr_q <= lptr_q + 7'd1;
      if (cmd_i.exec && exec_ok) begin
        // counter overflow after the step still keeps the new accumulator
        if (exec_setacc) acc_q <= exec_acc;
        if (exec_jump && st == ST_OK) pc_q <= opd_q;
        else if (exec_pcadv) pc_q <= pc_q + 7'd1;
      end
      if (cmd_i.emit) begin
        if (st != ST_OK && st != ST_STOPPED) stopped_q <= 1'b1;
        status_o      <= st;
        write_valid_o <= wv;
        write_word_o  <= ww;
      end
    end
  end

  assign acc_value_o = acc_q;
  assign pc_value_o  = pc_q;

  assign stat_o.clear_done = clear_done_q;
  assign stat_o.mode       = mode_q && !stopped_q;
  assign stat_o.div_needed = (op_q == OP_DIV) && !instr_q[WordW-1];
  assign stat_o.div_done   = div_done;
endmodule
`default_nettype wire

/* hw/rtl/dacc_ctrl.sv */
// sequencer for clear, load and instruction steps
`default_nettype none
module dacc_ctrl import dacc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DISP   = 9'b000000100,
    S_FETCH  = 9'b000001000,
    S_DECODE = 9'b000010000,
    S_OPER   = 9'b000100000,
    S_DIVW   = 9'b001000000,
    S_EXEC   = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) begin
          cmd_o.clear_step = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.mode) begin
          cmd_o.fetch = 1'b1;
          state_d = S_FETCH;
        end else begin
          cmd_o.do_load = 1'b1;
          cmd_o.emit    = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_FETCH: begin
        cmd_o.decode = 1'b1;
        state_d = S_DECODE;
      end
      S_DECODE: state_d = S_OPER;   // operand read in flight
      S_OPER: begin
        if (stat_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIVW;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_DIVW: if (stat_i.div_done) state_d = S_EXEC;
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.emit = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.emit;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
endmodule
`default_nettype wire

/* hw/rtl/dacc_checker.sv */
// port-level checks for the decimal accumulator cpu
`default_nettype none
module dacc_checker import dacc_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [3:0] status_o,
  input wire logic       write_valid_o
);
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without a step in flight");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
  a_wv_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_valid_o) |-> status_o == ST_OK) else $error("write with error");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held two cycles");
endmodule

bind decimal_accumulator_cpu dacc_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o, .write_valid_o
);
`default_nettype wire
